// File: src/mamn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mamn_pkg: shared types and constants of the moving-average normaliser
// Window depth, field widths, limits and the front/back command word.
// ----------------------------------------------------------------------------
package mamn_pkg;

  localparam int WINDOW_SIZE = 8;
  localparam int SLOT_W      = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int FILL_W      = $clog2(WINDOW_SIZE + 1);
  localparam int SUM_W       = 12 + $clog2(WINDOW_SIZE + 1);

  localparam logic [11:0] RAW_MAX       = 12'hFFF;
  localparam logic [19:0] MEAN_MAX      = 20'd1048320;
  localparam logic [19:0] ONE_LSB_Q8    = 20'd256;

  localparam int QUEUE_DEPTH = 2;

  // word passed from the front part to the back part
  typedef struct packed {
    logic [11:0]      sample;
    logic [SUM_W-1:0] sum;
    logic [FILL_W-1:0] fill;
  } mamn_cmd_t;

  typedef struct packed {
    logic [11:0] raw_value;
    logic [19:0] mean_value;
    logic [16:0] raw_normalized;
    logic [16:0] mean_normalized;
    logic [31:0] items_done;
  } mamn_res_t;

endpackage
`default_nettype wire

// File: src/mamn_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mamn_in_if: sample channel
// Valid/ready channel carrying one converter sample per word.
// ----------------------------------------------------------------------------
interface mamn_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

// File: src/mamn_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mamn_out_if: result channel
// Valid/ready channel carrying mean and normalised values per word.
// ----------------------------------------------------------------------------
interface mamn_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] raw_value;
  logic [19:0] mean_value;
  logic [16:0] raw_normalized;
  logic [16:0] mean_normalized;
  logic [31:0] items_done;
  modport source (output valid, output raw_value, output mean_value,
                  output raw_normalized, output mean_normalized,
                  output items_done, input ready);
  modport sink   (input valid, input raw_value, input mean_value,
                  input raw_normalized, input mean_normalized,
                  input items_done, output ready);
endinterface
`default_nettype wire

// File: src/mamn_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mamn_divider: radix-2 restoring divider
// 20-bit quotient of a 36-bit dividend by a 20-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module mamn_divider
  import mamn_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [35:0] dividend,
  input  wire logic [19:0] divisor,
  output logic             done,
  output logic [19:0]      quotient
);

  // the mean fits 20 bits and a normalised value 17 bits; the mean normalise
  // dividend is a 20-bit difference shifted by 16, so carry 36 steps.
  logic [35:0] quo_r, quo_nxt;
  logic [20:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [20:0] trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[19:0], quo_r[35]};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = 6'd35;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = trial - {1'b0, divisor};
        quo_nxt = {quo_r[34:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[34:0], 1'b0};
      end
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done     = done_r;
  assign quotient = (quo_r[35:20] != '0) ? 20'hFFFFF : quo_r[19:0];

endmodule
`default_nettype wire

// File: src/mamn_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mamn_front: window front end
// Accepts samples, updates the ring and running sum, queues a command word.
// ----------------------------------------------------------------------------
module mamn_front
  import mamn_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  mamn_in_if.sink    in_ch,
  output logic       cmd_valid,
  output mamn_cmd_t  cmd,
  input  wire logic  cmd_pop
);

  logic [11:0]       ring_r [WINDOW_SIZE];
  logic [SUM_W-1:0]  sum_r;
  logic [SLOT_W-1:0] slot_r;
  logic [FILL_W-1:0] fill_r;
  mamn_cmd_t         q_r [QUEUE_DEPTH];
  logic [1:0]        cnt_r;
  logic              rd_r, wr_r;
  logic              acc;
  logic [SUM_W-1:0]  sum_nxt;

  assign in_ch.ready = (cnt_r != 2'(QUEUE_DEPTH));
  assign acc         = in_ch.valid && in_ch.ready;
  assign sum_nxt     = sum_r - SUM_W'(ring_r[slot_r]) + SUM_W'(in_ch.sample);
  assign cmd_valid   = (cnt_r != 2'd0);
  assign cmd         = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_SIZE; i++) ring_r[i] <= '0;
      sum_r  <= '0;
      slot_r <= '0;
      fill_r <= '0;
      cnt_r  <= '0;
      rd_r   <= 1'b0;
      wr_r   <= 1'b0;
    end else begin
      if (acc) begin
        ring_r[slot_r] <= in_ch.sample;
        sum_r          <= sum_nxt;
        slot_r <= (slot_r == SLOT_W'(WINDOW_SIZE - 1)) ? '0 : slot_r + SLOT_W'(1);
        if (fill_r != FILL_W'(WINDOW_SIZE)) fill_r <= fill_r + FILL_W'(1);
        q_r[wr_r] <= '{sample: in_ch.sample, sum: sum_nxt,
                       fill: (fill_r != FILL_W'(WINDOW_SIZE)) ?
                             fill_r + FILL_W'(1) : fill_r};
        wr_r <= ~wr_r;
      end
      if (cmd_pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + 2'(acc) - 2'(cmd_pop);
    end
  end

endmodule
`default_nettype wire

// File: src/mamn_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mamn_back: mean and normalise back end
// Runs three divisions per word on a shared divider and tracks min/max.
// ----------------------------------------------------------------------------
module mamn_back
  import mamn_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  cmd_valid,
  input  mamn_cmd_t  cmd,
  output logic       cmd_pop,
  mamn_out_if.source out_ch
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MEAN = 5'b00010,
    S_RAWN = 5'b00100,
    S_MNN  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t      st_r;
  mamn_cmd_t   c_r;
  logic [11:0] rmin_r, rmax_r;
  logic [19:0] mmin_r, mmax_r;
  logic [19:0] mean_r;
  logic [16:0] rn_r, mn_r;
  logic [31:0] cnt_r;
  logic        wait_r;
  mamn_res_t   res_r;
  logic        ov_r;

  logic        go, done;
  logic [35:0] dvd;
  logic [19:0] dvs;
  logic [19:0] quo;
  logic [11:0] rmin_n, rmax_n;
  logic [19:0] mmin_n, mmax_n, mean_c;

  mamn_divider u_div (.clk(clk), .rst_n(rst_n), .start(go), .dividend(dvd),
                      .divisor(dvs), .done(done), .quotient(quo));

  assign rmin_n = (c_r.sample < rmin_r) ? c_r.sample : rmin_r;
  assign rmax_n = (c_r.sample > rmax_r) ? c_r.sample : rmax_r;
  assign mean_c = (quo > MEAN_MAX) ? MEAN_MAX : quo;
  assign mmin_n = (mean_r < mmin_r) ? mean_r : mmin_r;
  assign mmax_n = (mean_r > mmax_r) ? mean_r : mmax_r;

  assign cmd_pop = (st_r == S_IDLE) && cmd_valid;

  always_comb begin
    go  = 1'b0;
    dvd = '0;
    dvs = 20'd1;
    unique case (st_r)
      S_MEAN: begin
        dvd = 36'({c_r.sum, 8'd0});
        dvs = 20'(c_r.fill);
        go  = wait_r;
      end
      S_RAWN: begin
        dvd = 36'({12'(c_r.sample - rmin_n), 16'd0});
        dvs = (rmax_n == rmin_n) ? 20'd1 : 20'(rmax_n - rmin_n);
        go  = wait_r;
      end
      S_MNN: begin
        dvd = {20'(mean_r - mmin_n), 16'd0};
        dvs = ((mmax_n - mmin_n) < ONE_LSB_Q8) ? 20'd1 : mmax_n - mmin_n;
        go  = wait_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      wait_r <= 1'b0;
      ov_r   <= 1'b0;
      rmin_r <= RAW_MAX;
      rmax_r <= '0;
      mmin_r <= MEAN_MAX;
      mmax_r <= '0;
      cnt_r  <= '0;
    end else begin
      // load a new word or drop the one taken
      if ((st_r == S_OUT) && (!ov_r || out_ch.ready)) ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (cmd_valid) begin
          c_r    <= cmd;
          wait_r <= 1'b1;
          st_r   <= S_MEAN;
        end
        S_MEAN: begin
          wait_r <= 1'b0;
          if (done) begin
            mean_r <= mean_c;
            wait_r <= 1'b1;
            st_r   <= S_RAWN;
          end
        end
        S_RAWN: begin
          wait_r <= 1'b0;
          if (done) begin
            rn_r   <= (rmax_n == rmin_n) ? 17'd0 : quo[16:0];
            rmin_r <= rmin_n;
            rmax_r <= rmax_n;
            wait_r <= 1'b1;
            st_r   <= S_MNN;
          end
        end
        S_MNN: begin
          wait_r <= 1'b0;
          if (done) begin
            mn_r   <= ((mmax_n - mmin_n) < ONE_LSB_Q8) ? 17'd0 : quo[16:0];
            mmin_r <= mmin_n;
            mmax_r <= mmax_n;
            st_r   <= S_OUT;
          end
        end
        S_OUT: if (!ov_r || out_ch.ready) begin
          res_r <= '{raw_value: c_r.sample, mean_value: mean_r,
                     raw_normalized: rn_r, mean_normalized: mn_r,
                     items_done: cnt_r + 32'd1};
          cnt_r <= cnt_r + 32'd1;
          st_r  <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid           = ov_r;
  assign out_ch.raw_value       = res_r.raw_value;
  assign out_ch.mean_value      = res_r.mean_value;
  assign out_ch.raw_normalized  = res_r.raw_normalized;
  assign out_ch.mean_normalized = res_r.mean_normalized;
  assign out_ch.items_done      = res_r.items_done;

endmodule
`default_nettype wire

// File: src/moving_average_min_max_normalizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// moving_average_min_max_normalizer: windowed mean with min-max normalising
// The back end handles one sample at a time: it takes the word from the queue,
// runs three 36-step divisions (mean, raw normalise, mean normalise) one after
// another on one shared radix-2 divider, loads the output register, and only
// then takes the next word. A two-word queue between the front and back ends
// lets samples be taken while a result waits; the result sits in an output
// register and a stalled output holds the back end.
// ----------------------------------------------------------------------------
module moving_average_min_max_normalizer
  import mamn_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  mamn_in_if.sink   in_ch,
  mamn_out_if.source out_ch
);

  logic      cmd_valid, cmd_pop;
  mamn_cmd_t cmd;

  mamn_front u_front (.clk(clk), .rst_n(rst_n), .in_ch(in_ch),
                      .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop));

  mamn_back u_back (.clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd),
                    .cmd_pop(cmd_pop), .out_ch(out_ch));

endmodule
`default_nettype wire

// File: tb/mamn_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mamn_tb_if: testbench check record declarations
// The channels used by the test are the block's own interfaces; this file
// only holds the check record shared by the test.
// ----------------------------------------------------------------------------
package mamn_tb_pkg;
  import mamn_pkg::*;

  typedef struct {
    logic [11:0] sample;
    logic        has_fixed;
    mamn_res_t   fixed;
  } stim_row_t;
endpackage

// File: tb/moving_average_min_max_normalizer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moving_average_min_max_normalizer_test: self-checking test of the normaliser
// Drives samples through a random-gap valid/ready channel, predicts each
// result word with a local model of the window, mean and min-max tracking,
// and compares every field of every result word in order.
// ----------------------------------------------------------------------------
module moving_average_min_max_normalizer_test;
  import mamn_pkg::*;
  import mamn_tb_pkg::*;

  localparam int N_RANDOM  = 1200;
  localparam longint LIMIT = 5000000;

  logic clk;
  logic rst_n;
  mamn_in_if  in_ch();
  mamn_out_if out_ch();

  moving_average_min_max_normalizer DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // predictor state
  logic [11:0] win_ring [WINDOW_SIZE];
  logic [17:0] win_sum;
  int          win_slot;
  int          win_fill;
  logic [11:0] raw_lo, raw_hi;
  logic [19:0] mean_lo, mean_hi;
  logic [31:0] done_count;

  mamn_res_t  pending_results [$];
  int         errors;
  int         sent;
  int         received;
  longint     cycles;
  logic       input_done;
  int         sender_gap;
  bit         fixed_check [$];
  mamn_res_t  fixed_value [$];

  task automatic reset_window();
    for (int i = 0; i < WINDOW_SIZE; i++) win_ring[i] = '0;
    win_sum = '0; win_slot = 0; win_fill = 0;
    raw_lo = RAW_MAX; raw_hi = '0;
    mean_lo = MEAN_MAX; mean_hi = '0;
    done_count = '0;
  endtask

  function automatic logic [16:0] scale_q16(logic [19:0] x, logic [19:0] lo,
                                            logic [19:0] hi, logic [19:0] floor_spread);
    logic [19:0] spread;
    logic [47:0] num;
    if (hi < lo) return '0;
    spread = hi - lo;
    if (spread < floor_spread || spread == 0) return '0;
    num = 48'(x - lo) << 16;
    return 17'(num / spread);
  endfunction

  function automatic mamn_res_t advance_window(logic [11:0] raw);
    mamn_res_t r;
    logic [27:0] mean_w;
    win_sum = win_sum - win_ring[win_slot] + raw;
    win_ring[win_slot] = raw;
    win_slot = (win_slot + 1) % WINDOW_SIZE;
    if (win_fill < WINDOW_SIZE) win_fill++;
    mean_w = 28'((28'(win_sum) << 8) / 28'(win_fill));
    if (mean_w > MEAN_MAX) mean_w = MEAN_MAX;
    if (raw < raw_lo) raw_lo = raw;
    if (raw > raw_hi) raw_hi = raw;
    if (mean_w[19:0] < mean_lo) mean_lo = mean_w[19:0];
    if (mean_w[19:0] > mean_hi) mean_hi = mean_w[19:0];
    done_count++;
    r.raw_value       = raw;
    r.mean_value      = mean_w[19:0];
    r.raw_normalized  = scale_q16({8'd0, raw}, {8'd0, raw_lo}, {8'd0, raw_hi}, 20'd1);
    r.mean_normalized = scale_q16(mean_w[19:0], mean_lo, mean_hi, ONE_LSB_Q8);
    r.items_done      = done_count;
    return r;
  endfunction

  // directed rows: first result after reset, extremes, flat signal, steps
  stim_row_t dir_rows [$];

  task automatic add_row(logic [11:0] s, logic has, mamn_res_t f);
    stim_row_t row;
    row.sample = s; row.has_fixed = has; row.fixed = f;
    dir_rows.push_back(row);
  endtask

  task automatic send_sample(logic [11:0] s, bit has, mamn_res_t f);
    mamn_res_t predicted;
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    do @(posedge clk); while (!in_ch.ready);
    predicted = advance_window(s);
    pending_results.push_back(predicted);
    fixed_check.push_back(has);
    fixed_value.push_back(f);
    sent++;
    sender_gap = ($urandom_range(0, 9) < 6) ? 0 :
                 ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(20, 200);
    if (sender_gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (sender_gap) @(posedge clk);
    end
  endtask

  // stimulus
  initial begin
    mamn_res_t f;
    mamn_res_t z;
    logic [11:0] s;
    z = '0;
    in_ch.valid = 1'b0; in_ch.sample = '0;
    rst_n = 1'b0; errors = 0; sent = 0; received = 0; input_done = 1'b0;
    reset_window();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first word: min=max, mean spread zero
    f = '{raw_value: 12'hFFF, mean_value: MEAN_MAX, raw_normalized: '0,
          mean_normalized: '0, items_done: 32'd1};
    add_row(12'hFFF, 1'b1, f);
    add_row(12'h000, 1'b0, z);
    add_row(12'hFFF, 1'b0, z);
    for (int i = 0; i < 8; i++) add_row(12'h000, 1'b0, z);
    for (int i = 0; i < 8; i++) add_row(12'hFFF, 1'b0, z);
    add_row(12'h555, 1'b0, z);
    add_row(12'hAAA, 1'b0, z);
    add_row(12'h001, 1'b0, z);
    add_row(12'h800, 1'b0, z);
    add_row(12'h7FF, 1'b0, z);
    foreach (dir_rows[i]) send_sample(dir_rows[i].sample, dir_rows[i].has_fixed,
                                      dir_rows[i].fixed);

    // hold until the block has drained
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);

    // fresh window state only via natural drift: mix full-range, near-0x800, extreme and random samples
    for (int i = 0; i < N_RANDOM; i++) begin
      case ($urandom_range(0, 3))
        0: s = 12'($urandom_range(0, 4095));
        1: s = 12'(12'h800 + $urandom_range(0, 3));
        2: s = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
        default: s = 12'($urandom);
      endcase
      send_sample(s, 1'b0, z);
    end
    in_ch.valid <= 1'b0;
    input_done = 1'b1;
  end

  // result side with random stalls
  initial begin
    mamn_res_t want;
    bit has;
    mamn_res_t fx;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        received++;
        if (pending_results.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          want = pending_results.pop_front();
          has = fixed_check.pop_front();
          fx = fixed_value.pop_front();
          // rows with a typed-in result are checked against that value
          if (has) want = fx;
          if (out_ch.raw_value !== want.raw_value) begin
            $error("raw_value exp %0d got %0d", want.raw_value, out_ch.raw_value); errors++;
          end
          if (out_ch.mean_value !== want.mean_value) begin
            $error("mean_value exp %0d got %0d", want.mean_value, out_ch.mean_value); errors++;
          end
          if (out_ch.raw_normalized !== want.raw_normalized) begin
            $error("raw_normalized exp %0d got %0d", want.raw_normalized,
                   out_ch.raw_normalized); errors++;
          end
          if (out_ch.mean_normalized !== want.mean_normalized) begin
            $error("mean_normalized exp %0d got %0d", want.mean_normalized,
                   out_ch.mean_normalized); errors++;
          end
          if (out_ch.items_done !== want.items_done) begin
            $error("items_done exp %0d got %0d", want.items_done, out_ch.items_done); errors++;
          end
        end
      end
      if ($urandom_range(0, 199) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(20, 300)) @(posedge clk);
      end else begin
        case ($urandom_range(0, 19))
          0: out_ch.ready <= 1'b0;
          1, 2, 3: out_ch.ready <= ~out_ch.ready;
          default: out_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  // end of run and watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
      if (input_done && pending_results.size() == 0) begin
        repeat (200) @(posedge clk);
        if (out_ch.valid) begin
          $error("result word left over after the last expected one");
          errors++;
        end
        $display("Covered %0d samples (%0d results) incl. extremes, flat and step runs.",
                 sent, received);
        if (errors == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
      end
    end
  end

endmodule
